### rtl/sspan_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sspan_pkg
// Shared types, codes and constants of the spread and azimuth pan mixer.
// ----------------------------------------------------------------------------
package sspan_pkg;

	localparam int SAMPLE_W = 24;
	localparam int POS_W    = 32;
	localparam int GAIN_W   = 18;

	// request kinds carried in tuser
	localparam logic [1:0] REQ_FRAME = 2'd0;
	localparam logic [1:0] REQ_WORD  = 2'd1;
	localparam logic [1:0] REQ_GEO   = 2'd2;
	localparam logic [1:0] REQ_RSVD  = 2'd3;

	// configuration register indexes
	localparam logic [2:0] CFG_BLEND  = 3'd0;
	localparam logic [2:0] CFG_REVERB = 3'd1;
	localparam logic [2:0] CFG_PAN    = 3'd2;
	localparam logic [2:0] CFG_SPREAD = 3'd3;
	localparam logic [2:0] CFG_BYPASS = 3'd4;

	localparam logic [4:0] WORD_LAST = 5'd18;

	localparam logic [16:0] GAIN_ONE     = 17'd65536;
	localparam logic [31:0] HALF_DEG_Q30 = 32'd9370165;
	localparam logic [31:0] Z_MIN_RAW    = 32'd66;

	typedef logic signed [POS_W-1:0] word_t;

	typedef enum logic [3:0] {
		G_IDLE,
		G_MAT_MUL,
		G_MAT_ACC,
		G_COS_SQ,
		G_COS_MUL,
		G_COS_DIV_GO,
		G_COS_DIV_WAIT,
		G_AZ_CHK,
		G_AZ_NORM,
		G_AZ_SQX,
		G_AZ_SQZ,
		G_SQRT,
		G_AZ_PREP,
		G_AZ_DIV_GO,
		G_AZ_DIV_WAIT
	} geo_state_t;

	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
	} lane_ctl_t;

	typedef struct packed {
		logic signed [18:0] own_gain;
		logic signed [17:0] spread_gain;
		logic [17:0]        az_gain;
		logic [16:0]        pan_gain;
		logic [16:0]        blend;
		logic [16:0]        mix;
	} lane_cfg_t;

	// cosine series divisors 90, 56, 30, 12, 2 as a pre-shift by the power
	// of two, then a multiply by the rounded-up reciprocal of the odd part;
	// exact for every dividend below 2^32
	function automatic logic [1:0] cos_pre(input logic [2:0] idx);
		case (idx)
			3'd0: cos_pre = 2'd1;
			3'd1: cos_pre = 2'd3;
			3'd2: cos_pre = 2'd1;
			3'd3: cos_pre = 2'd2;
			default: cos_pre = 2'd1;
		endcase
	endfunction

	function automatic logic [31:0] cos_mag(input logic [2:0] idx);
		case (idx)
			3'd0: cos_mag = 32'd3054198967;
			3'd1: cos_mag = 32'd2454267027;
			3'd2: cos_mag = 32'd2290649225;
			3'd3: cos_mag = 32'd2863311531;
			default: cos_mag = 32'd2147483648;
		endcase
	endfunction

	function automatic logic [5:0] cos_sft(input logic [2:0] idx);
		case (idx)
			3'd0: cos_sft = 6'd37;
			3'd1: cos_sft = 6'd34;
			3'd2: cos_sft = 6'd35;
			3'd3: cos_sft = 6'd33;
			default: cos_sft = 6'd31;
		endcase
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] sat_samp(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = (64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		if (v > hi) sat_samp = SAMPLE_W'(hi);
		else if (v < lo) sat_samp = SAMPLE_W'(lo);
		else sat_samp = SAMPLE_W'(v);
	endfunction

endpackage
`default_nettype wire

### rtl/sspan_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sspan_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sspan_div import sspan_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [47:0] quo
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [31:0] rem_q;
	logic [47:0] quo_q;
	logic [31:0] den_q;
	logic [32:0] rem_sh;
	logic        ge;

	assign rem_sh = {rem_q, quo_q[47]};
	assign ge     = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd47) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? 32'(rem_sh - {1'b0, den_q}) : rem_sh[31:0];
			quo_q <= {quo_q[46:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
`default_nettype wire

### rtl/sspan_geom.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sspan_geom
// Geometry sequencer: source into listener space, spread cosine, azimuth gain.
// ----------------------------------------------------------------------------
module sspan_geom import sspan_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  word_t                    xform [16],
	input  word_t                    pos [3],
	input  logic [8:0]               spread_angle,
	output logic                     busy,
	output logic signed [GAIN_W-1:0] spread_gain,
	output logic signed [GAIN_W-1:0] az_gain
);

	geo_state_t state_q, state_nxt;

	logic [1:0]          i_q, j_q;
	logic signed [51:0]  acc_q, acc_nxt;
	logic signed [65:0]  prod_q;
	logic signed [31:0]  d0_q, d2_q, d_sat;
	logic [31:0]         t2_q;
	logic [31:0]         cq_q;
	logic signed [32:0]  r_q, r_nxt, r_clip;
	logic [2:0]          cidx_q;
	logic [47:0]         num_q;
	logic [31:0]         ax_q, az_q, ax_abs, az_abs;
	logic [61:0]         rem_q, res_q, bit_q;
	logic [62:0]         trial;
	logic signed [GAIN_W-1:0] spread_gain_q, az_gain_q;

	logic signed [32:0]  mul_a, mul_b;
	logic signed [65:0]  mul_p;
	logic                div_start, div_done;
	logic [31:0]         div_den;
	logic [47:0]         div_quo;

	logic [8:0]          sa;
	logic                cos_neg;
	logic [7:0]          k;
	logic [31:0]         t_val;
	logic [16:0]         cos_rnd;
	logic [16:0]         az_mag;

	// half-angle index, mirrored above ninety degrees
	assign sa      = (spread_angle > 9'd360) ? 9'd360 : spread_angle;
	assign cos_neg = sa > 9'd180;
	assign k       = cos_neg ? 8'(9'd360 - sa) : sa[7:0];
	assign t_val   = 32'(k) * HALF_DEG_Q30;

	assign acc_nxt = acc_q + 52'($signed(prod_q[65:16]));
	always_comb begin
		if (acc_nxt > 52'sd2147483647) d_sat = 32'sh7FFFFFFF;
		else if (acc_nxt < -52'sd2147483648) d_sat = 32'sh80000000;
		else d_sat = acc_nxt[31:0];
	end

	assign r_nxt   = 33'sd1073741824 - $signed({1'b0, cq_q});
	assign r_clip  = r_nxt[32] ? 33'sd0 : r_nxt;
	assign cos_rnd = 17'((r_clip + 33'sd8192) >>> 14);

	assign ax_abs = d0_q[31] ? 32'(~d0_q + 32'sd1) : 32'(d0_q);
	assign az_abs = d2_q[31] ? 32'(~d2_q + 32'sd1) : 32'(d2_q);
	assign trial  = 63'(res_q) + 63'(bit_q);
	assign az_mag = (div_quo > 48'(GAIN_ONE)) ? GAIN_ONE : div_quo[16:0];

	assign mul_p = mul_a * mul_b;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			G_IDLE:         if (start) state_nxt = G_MAT_MUL;
			G_MAT_MUL:      state_nxt = G_MAT_ACC;
			G_MAT_ACC: begin
				if (j_q == 2'd2 && i_q == 2'd2) state_nxt = G_COS_SQ;
				else state_nxt = G_MAT_MUL;
			end
			G_COS_SQ:       state_nxt = G_COS_DIV_GO;
			G_COS_MUL:      state_nxt = G_COS_DIV_GO;
			G_COS_DIV_GO:   state_nxt = G_COS_DIV_WAIT;
			G_COS_DIV_WAIT: state_nxt = (cidx_q == 3'd4) ? G_AZ_CHK : G_COS_MUL;
			G_AZ_CHK:       state_nxt = (az_abs < Z_MIN_RAW) ? G_IDLE : G_AZ_NORM;
			G_AZ_NORM:      if (!(|ax_q[31:30] || |az_q[31:30])) state_nxt = G_AZ_SQX;
			G_AZ_SQX:       state_nxt = G_AZ_SQZ;
			G_AZ_SQZ:       state_nxt = G_SQRT;
			G_SQRT:         if (bit_q == 62'd1) state_nxt = G_AZ_PREP;
			G_AZ_PREP:      state_nxt = G_AZ_DIV_GO;
			G_AZ_DIV_GO:    state_nxt = G_AZ_DIV_WAIT;
			G_AZ_DIV_WAIT:  if (div_done) state_nxt = G_IDLE;
			default:        state_nxt = G_IDLE;
		endcase
	end

	// multiplier operands and divider control
	always_comb begin
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_den   = res_q[31:0];
		case (state_q)
			G_MAT_MUL: begin
				mul_a = 33'(xform[{j_q, i_q}]);
				mul_b = 33'(pos[j_q]);
			end
			G_COS_SQ: begin
				mul_a = $signed({1'b0, t_val});
				mul_b = $signed({1'b0, t_val});
			end
			G_COS_MUL: begin
				mul_a = $signed({1'b0, t2_q});
				mul_b = r_q[32] ? 33'sd0 : r_q;
			end
			// series step divide: reciprocal multiply
			G_COS_DIV_GO: begin
				mul_a = $signed({1'b0, 32'(num_q >> cos_pre(cidx_q))});
				mul_b = $signed({1'b0, cos_mag(cidx_q)});
			end
			G_AZ_SQX: begin
				mul_a = $signed({1'b0, ax_q});
				mul_b = $signed({1'b0, ax_q});
			end
			G_AZ_SQZ: begin
				mul_a = $signed({1'b0, az_q});
				mul_b = $signed({1'b0, az_q});
			end
			G_AZ_DIV_GO: div_start = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= G_IDLE;
			spread_gain_q <= GAIN_W'(GAIN_ONE);
			az_gain_q     <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == G_COS_DIV_WAIT && cidx_q == 3'd4)
				spread_gain_q <= cos_neg ? -GAIN_W'(cos_rnd) : GAIN_W'(cos_rnd);
			if (state_q == G_AZ_CHK && az_abs < Z_MIN_RAW)
				az_gain_q <= '0;
			if (state_q == G_AZ_DIV_WAIT && div_done)
				az_gain_q <= d0_q[31] ? -GAIN_W'(az_mag) : GAIN_W'(az_mag);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			G_IDLE: begin
				i_q   <= 2'd0;
				j_q   <= 2'd0;
				acc_q <= 52'(xform[12]);
			end
			G_MAT_MUL: prod_q <= mul_p;
			G_MAT_ACC: begin
				if (j_q == 2'd2) begin
					if (i_q == 2'd0) d0_q <= d_sat;
					else d2_q <= d_sat;
					i_q   <= 2'd2;
					j_q   <= 2'd0;
					acc_q <= 52'(xform[14]);
				end else begin
					j_q   <= j_q + 2'd1;
					acc_q <= acc_nxt;
				end
			end
			G_COS_SQ: begin
				t2_q   <= mul_p[61:30];
				num_q  <= 48'(mul_p[61:30]);
				cidx_q <= 3'd0;
			end
			G_COS_MUL: num_q <= 48'(mul_p[61:30]);
			G_COS_DIV_GO: cq_q <= 32'(mul_p >>> cos_sft(cidx_q));
			G_COS_DIV_WAIT: begin
				r_q    <= r_nxt;
				cidx_q <= cidx_q + 3'd1;
			end
			G_AZ_CHK: begin
				ax_q <= ax_abs;
				az_q <= az_abs;
			end
			G_AZ_NORM: begin
				if (|ax_q[31:30] || |az_q[31:30]) begin
					ax_q <= ax_q >> 1;
					az_q <= az_q >> 1;
				end
			end
			G_AZ_SQX: rem_q <= 62'(mul_p[59:0]);
			G_AZ_SQZ: begin
				rem_q <= rem_q + 62'(mul_p[59:0]);
				res_q <= '0;
				bit_q <= 62'd1 << 60;
			end
			G_SQRT: begin
				if (63'(rem_q) >= trial) begin
					rem_q <= rem_q - 62'(trial);
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			G_AZ_PREP: num_q <= {2'b0, ax_q[29:0], 16'b0} + 48'(res_q[31:1]);
			default: ;
		endcase
	end

	sspan_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign busy        = state_q != G_IDLE;
	assign spread_gain = spread_gain_q;
	assign az_gain     = az_gain_q;

endmodule
`default_nettype wire

### rtl/sspan_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sspan_lane
// One output channel: spread, azimuth weight, pan, blend and reverb send.
// ----------------------------------------------------------------------------
module sspan_lane import sspan_pkg::*; (
	input  logic                       clk,
	input  lane_ctl_t                  ctl,
	input  lane_cfg_t                  cfg,
	input  logic signed [SAMPLE_W-1:0] own_in,
	input  logic signed [SAMPLE_W-1:0] other_in,
	output logic signed [SAMPLE_W-1:0] samp_out,
	output logic signed [SAMPLE_W-1:0] rev_out
);

	logic signed [42:0] p_own_s1;
	logic signed [41:0] p_oth_s1, p_st_s1;
	logic signed [47:0] spatial_s2;
	logic signed [42:0] stereo_s2;
	logic signed [52:0] o16_s3;
	logic signed [SAMPLE_W-1:0] o_s4, rv_s4;

	logic signed [43:0] spread;
	logic signed [46:0] sp_hm;
	logic [34:0]        sp_lm;
	logic signed [48:0] diff;
	logic signed [50:0] bl_hm;
	logic [34:0]        bl_lm;
	logic signed [53:0] rnd;
	logic signed [SAMPLE_W-1:0] o_val;
	logic signed [25:0] rv_hm;
	logic [34:0]        rv_lm;
	logic signed [27:0] rv_sum;

	// gain products round to nearest, ties up: high part times gain plus
	// rounded low part times gain
	assign spread = 44'(p_own_s1) + 44'(p_oth_s1);
	assign sp_hm  = $signed(spread[43:16]) * $signed({1'b0, cfg.az_gain});
	assign sp_lm  = 35'(spread[15:0]) * 35'(cfg.az_gain) + 35'd32768;

	assign diff  = 49'(spatial_s2) - 49'(stereo_s2);
	assign bl_hm = $signed(diff[48:16]) * $signed({1'b0, cfg.blend});
	assign bl_lm = 35'(diff[15:0]) * 35'(cfg.blend) + 35'd32768;

	assign rnd    = 54'(o16_s3) + 54'sd32768;
	assign o_val  = sat_samp(64'($signed(rnd[53:16])));
	assign rv_hm  = $signed(o_val[23:16]) * $signed({1'b0, cfg.mix});
	assign rv_lm  = 35'(o_val[15:0]) * 35'(cfg.mix) + 35'd32768;
	assign rv_sum = 28'(rv_hm) + $signed({10'b0, rv_lm[33:16]});

	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			p_own_s1 <= own_in * cfg.own_gain;
			p_oth_s1 <= other_in * cfg.spread_gain;
			p_st_s1  <= own_in * $signed({1'b0, cfg.pan_gain});
		end
		if (ctl.en_s2) begin
			spatial_s2 <= 48'(sp_hm) + $signed({30'b0, sp_lm[33:16]});
			stereo_s2  <= {p_st_s1, 1'b0};
		end
		if (ctl.en_s3)
			o16_s3 <= 53'(stereo_s2) + 53'(bl_hm) + $signed({35'b0, bl_lm[33:16]});
		if (ctl.en_s4) begin
			o_s4  <= o_val;
			rv_s4 <= sat_samp(64'(rv_sum));
		end
	end

	assign samp_out = o_s4;
	assign rev_out  = rv_s4;

endmodule
`default_nettype wire

### rtl/stereo_spread_azimuth_pan_mixer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_spread_azimuth_pan_mixer
// Stereo spread and azimuth panner with stereo pan blend and reverb send.
// ----------------------------------------------------------------------------
// One input transaction carries a stereo frame, a listener transform or source
// position word, or a geometry update, selected by tuser. A stereo frame runs
// through two identical channel lanes of four stages and the result lands in
// the output register; the input is not ready again until the frame has left
// the last stage, and the output register lets the next frame enter while a
// result waits. A geometry update runs a sequencer with one shared 33x33
// multiplier: six multiply-accumulate steps for x and z, five cosine series
// steps each divided by a reciprocal multiply, a 31-step square root and a
// one-bit-per-cycle divider for the azimuth ratio; the input is not ready
// while it runs. Frames and word writes produce no result other than the one
// frame result each. The user must write configuration registers only while
// the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module stereo_spread_azimuth_pan_mixer import sspan_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,  // left_in, right_in, word_index, word_value, zero pad
	input  logic [1:0]  s_tuser,  // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,  // left_out, right_out, reverb_left, reverb_right
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [16:0] cfg_wdata
);

	logic [16:0]        blend_q, mix_q;
	logic signed [15:0] pan_q;
	logic [8:0]         spread_q;
	logic               bypass_q;

	word_t xform_q [16];
	word_t pos_q [3];

	logic               in_xfer, frame_xfer, word_xfer, geo_start;
	logic [4:0]         w_idx;
	word_t              w_val;
	logic signed [SAMPLE_W-1:0] left_in, right_in;
	logic signed [SAMPLE_W-1:0] left_q, right_q;

	logic               v_s1, v_s2, v_s3, v_s4;
	logic               out_load;
	logic               m_tvalid_q;
	logic [95:0]        m_tdata_q;

	logic               geo_busy;
	logic signed [GAIN_W-1:0] spread_gain, az_gain;
	lane_ctl_t          lane_ctl;
	lane_cfg_t          cfg_l, cfg_r;
	logic signed [SAMPLE_W-1:0] l_out, r_out, l_rev, r_rev;
	logic [16:0]        blend_c, mix_c;

	assign left_in  = s_tdata[23:0];
	assign right_in = s_tdata[47:24];
	assign w_idx    = s_tdata[52:48];
	assign w_val    = s_tdata[84:53];

	// one item at a time: nothing in the lanes and the sequencer idle
	assign s_tready   = !(v_s1 || v_s2 || v_s3 || v_s4) && !geo_busy;
	assign in_xfer    = s_tvalid && s_tready;
	assign frame_xfer = in_xfer && s_tuser == REQ_FRAME;
	assign word_xfer  = in_xfer && s_tuser == REQ_WORD;
	assign geo_start  = in_xfer && s_tuser == REQ_GEO;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_q  <= '0;
			mix_q    <= '0;
			pan_q    <= '0;
			spread_q <= '0;
			bypass_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BLEND:  blend_q  <= cfg_wdata;
				CFG_REVERB: mix_q    <= cfg_wdata;
				CFG_PAN:    pan_q    <= cfg_wdata[15:0];
				CFG_SPREAD: spread_q <= cfg_wdata[8:0];
				CFG_BYPASS: bypass_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// listener transform 0..15, then source x, y, z; higher indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) xform_q[i] <= '0;
			for (int i = 0; i < 3; i++) pos_q[i] <= '0;
		end else if (word_xfer) begin
			if (!w_idx[4]) xform_q[w_idx[3:0]] <= w_val;
			else if (w_idx <= WORD_LAST) pos_q[w_idx[1:0]] <= w_val;
		end
	end

	sspan_geom u_geom (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (geo_start),
		.xform        (xform_q),
		.pos          (pos_q),
		.spread_angle (spread_q),
		.busy         (geo_busy),
		.spread_gain  (spread_gain),
		.az_gain      (az_gain)
	);

	// per-channel gains: left gets 1 - a and the positive pan cut,
	// right gets 1 + a and the negative pan cut
	assign blend_c = (blend_q > GAIN_ONE) ? GAIN_ONE : blend_q;
	assign mix_c   = (mix_q > GAIN_ONE) ? GAIN_ONE : mix_q;

	always_comb begin
		cfg_l.own_gain    = 19'sd131072 - 19'(spread_gain);
		cfg_l.spread_gain = spread_gain;
		cfg_l.az_gain     = 18'(19'sd65536 - 19'(az_gain));
		cfg_l.pan_gain    = (pan_q > 16'sd0) ? 17'(17'd32768 - 17'(pan_q)) : 17'd32768;
		cfg_l.blend       = blend_c;
		cfg_l.mix         = mix_c;
		cfg_r             = cfg_l;
		cfg_r.az_gain     = 18'(19'sd65536 + 19'(az_gain));
		cfg_r.pan_gain    = (pan_q < 16'sd0) ? 17'(17'd32768 + 17'(pan_q)) : 17'd32768;
	end

	// a frame token walks the lane stages; the last stage holds while the
	// output register is still full
	assign out_load = v_s4 && (!m_tvalid_q || m_tready);

	always_comb begin
		lane_ctl.en_s1 = frame_xfer;
		lane_ctl.en_s2 = v_s1;
		lane_ctl.en_s3 = v_s2;
		lane_ctl.en_s4 = v_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			v_s4       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			v_s1 <= frame_xfer;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s3) v_s4 <= 1'b1;
			else if (out_load) v_s4 <= 1'b0;
			if (out_load) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_xfer) begin
			left_q  <= left_in;
			right_q <= right_in;
		end
	end

	sspan_lane u_lane_l (
		.clk      (clk),
		.ctl      (lane_ctl),
		.cfg      (cfg_l),
		.own_in   (left_in),
		.other_in (right_in),
		.samp_out (l_out),
		.rev_out  (l_rev)
	);

	sspan_lane u_lane_r (
		.clk      (clk),
		.ctl      (lane_ctl),
		.cfg      (cfg_r),
		.own_in   (right_in),
		.other_in (left_in),
		.samp_out (r_out),
		.rev_out  (r_rev)
	);

	// merge: both lanes into one result transaction, bypass passes the raw frame
	always_ff @(posedge clk) begin
		if (out_load) begin
			if (bypass_q) m_tdata_q <= {48'b0, right_q, left_q};
			else m_tdata_q <= {r_rev, l_rev, r_out, l_out};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// only one frame in the lanes at a time
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({v_s1, v_s2, v_s3, v_s4}))
		else $error("more than one frame in the lanes");

	// a taken frame enters the first lane stage
	a_frame_enters: assert property (@(posedge clk) disable iff (!arst_n)
		frame_xfer |=> v_s1)
		else $error("accepted frame lost");

	// a finished frame stays in the last stage while the output is blocked
	a_hold_last: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && m_tvalid_q && !m_tready) |=> v_s4)
		else $error("result dropped while output blocked");

	// no item is taken while the geometry sequencer runs
	a_geo_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		geo_start |=> (geo_busy && !s_tready))
		else $error("geometry update not blocking input");

endmodule
`default_nettype wire

### bench/stereo_spread_azimuth_pan_mixer_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Spread and azimuth pan mixer checker
// Watches the input, output and register write channels, predicts each
// frame result from its own model of the mixer, compares field by field.
// ----------------------------------------------------------------------------
module stereo_spread_azimuth_pan_mixer_check import sspan_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [87:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [95:0] m_tdata,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [16:0] cfg_wdata,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [23:0] rv_r;
		logic [23:0] rv_l;
		logic [23:0] r_out;
		logic [23:0] l_out;
	} mix_out_t;

	mix_out_t frame_q[$];

	longint mtx[16];
	longint src[3];
	longint az_g, spr_g, pan_v;
	int unsigned blend_r, mix_r, angle_r, byp_r;

	function automatic longint sar(longint x, int s);
		return x >>> s;
	endfunction

	function automatic longint clip(longint x, int bits);
		longint hi, lo;
		hi = (64'sd1 <<< (bits - 1)) - 1;
		lo = -hi - 1;
		return x > hi ? hi : (x < lo ? lo : x);
	endfunction

	// round(a*g/65536), ties up
	function automatic longint gmul(longint a, longint g);
		longint hi, lo;
		hi = a >>> 16;
		lo = a - hi * 65536;
		return hi * g + ((lo * g + 32768) >>> 16);
	endfunction

	function automatic longint root(longint n);
		longint res, b;
		res = 0;
		b = 64'sd1 <<< 62;
		while (b > n) b = b >>> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >>> 1) + b;
			end else res = res >>> 1;
			b = b >>> 2;
		end
		return res;
	endfunction

	function automatic longint cos_half(int unsigned k);
		logic neg;
		longint unsigned t, t2, p;
		longint r;
		int dv[4];
		dv = '{56, 30, 12, 2};
		neg = 0;
		if (k > 360) k = 360;
		if (k > 180) begin
			k = 360 - k;
			neg = 1;
		end
		t = longint'(k) * 64'd9370165;
		t2 = (t * t) >> 30;
		r = 64'sd1073741824 - longint'(t2) / 90;
		for (int i = 0; i < 4; i++) begin
			if (r < 0) r = 0;
			p = (t2 * longint'(r)) >> 30;
			r = 64'sd1073741824 - longint'(p) / dv[i];
		end
		if (r < 0) r = 0;
		r = (r + 8192) >>> 14;
		return neg ? -r : r;
	endfunction

	task automatic update_geometry();
		longint d[3];
		longint acc;
		longint unsigned ax, az, q, r, p;
		for (int i = 0; i < 3; i++) begin
			acc = mtx[12 + i];
			for (int j = 0; j < 3; j++) acc += sar(mtx[4 * j + i] * src[j], 16);
			d[i] = clip(acc, 32);
		end
		spr_g = cos_half(angle_r);
		az = d[2] < 0 ? -d[2] : d[2];
		if (az < 66) begin
			az_g = 0;
			return;
		end
		ax = d[0] < 0 ? -d[0] : d[0];
		while (ax >= (64'd1 << 30) || az >= (64'd1 << 30)) begin
			ax >>= 1;
			az >>= 1;
		end
		q = ax * ax + az * az;
		r = root(q);
		if (r == 0) begin
			az_g = 0;
			return;
		end
		p = ((ax << 16) + r / 2) / r;
		if (p > 65536) p = 65536;
		az_g = d[0] < 0 ? -longint'(p) : longint'(p);
	endtask

	function automatic mix_out_t mix_frame(longint xl, longint xr);
		mix_out_t res;
		longint x[2], o[2], rv[2];
		longint own, sp, azg, spat, pv, pg, st, o16;
		longint bl, mx;
		x[0] = xl;
		x[1] = xr;
		if (byp_r) begin
			res.l_out = xl[23:0];
			res.r_out = xr[23:0];
			res.rv_l = '0;
			res.rv_r = '0;
			return res;
		end
		bl = blend_r > 65536 ? 65536 : blend_r;
		mx = mix_r > 65536 ? 65536 : mix_r;
		own = 2 * 65536 - spr_g;
		for (int c = 0; c < 2; c++) begin
			sp = x[c] * own + x[1 - c] * spr_g;
			azg = c == 0 ? 65536 - az_g : 65536 + az_g;
			spat = gmul(sp, azg);
			pv = c == 0 ? pan_v : -pan_v;
			pg = 32768 - (pv > 0 ? pv : 0);
			st = x[c] * pg * 2;
			o16 = st + gmul(spat - st, bl);
			o[c] = clip((o16 + 32768) >>> 16, 24);
			rv[c] = clip(gmul(o[c], mx), 24);
		end
		res.l_out = o[0][23:0];
		res.r_out = o[1][23:0];
		res.rv_l = rv[0][23:0];
		res.rv_r = rv[1][23:0];
		return res;
	endfunction

	task automatic compare(string name, logic [23:0] exp_v, logic [23:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %0d actual %0d", name,
				$signed(exp_v), $signed(act_v));
			fail_count++;
		end
	endtask

	assign pending = frame_q.size();

	always @(posedge clk or negedge arst_n) begin
		mix_out_t e;
		mix_out_t a;
		if (!arst_n) begin
			foreach (mtx[i]) mtx[i] = 0;
			foreach (src[i]) src[i] = 0;
			az_g = 0;
			spr_g = 65536;
			pan_v = 0;
			blend_r = 0;
			mix_r = 0;
			angle_r = 0;
			byp_r = 0;
			fail_count = 0;
			frame_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_BLEND:  blend_r = cfg_wdata;
					CFG_REVERB: mix_r = cfg_wdata;
					CFG_PAN:    pan_v = longint'($signed(cfg_wdata[15:0]));
					CFG_SPREAD: angle_r = cfg_wdata[8:0];
					CFG_BYPASS: byp_r = cfg_wdata[0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				case (s_tuser)
					REQ_FRAME: frame_q.push_back(mix_frame(
						longint'($signed(s_tdata[23:0])),
						longint'($signed(s_tdata[47:24]))));
					REQ_WORD: begin
						if (s_tdata[52:48] < 16)
							mtx[s_tdata[52:48]] = longint'($signed(s_tdata[84:53]));
						else if (s_tdata[52:48] <= WORD_LAST)
							src[s_tdata[52:48] - 16] = longint'($signed(s_tdata[84:53]));
					end
					REQ_GEO: update_geometry();
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				a = m_tdata;
				if (frame_q.size() == 0) begin
					$error("result transaction with no frame waiting");
					fail_count++;
				end else begin
					e = frame_q.pop_front();
					compare("left_out", e.l_out, a.l_out);
					compare("right_out", e.r_out, a.r_out);
					compare("reverb_left", e.rv_l, a.rv_l);
					compare("reverb_right", e.rv_r, a.rv_r);
				end
			end
		end
	end

endmodule

### bench/stereo_spread_azimuth_pan_mixer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Spread and azimuth pan mixer test
// Directed and random frames, word writes and geometry updates under
// several register settings and back-pressure patterns; a checker compares.
// ----------------------------------------------------------------------------
module stereo_spread_azimuth_pan_mixer_test;
	import sspan_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [87:0] s_tdata = '0;   // left_in, right_in, word_index, word_value
	logic [1:0]  s_tuser = '0;   // req_type
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [95:0] m_tdata;        // left_out, right_out, reverb_left, reverb_right
	logic        cfg_we = 0;
	logic [2:0]  cfg_index = '0;
	logic [16:0] cfg_wdata = '0;

	int fail_count;
	int pending;
	int unsigned cycle_count = 0;
	int unsigned send_idle = 0;   // percent idle on the input side
	int unsigned recv_idle = 0;   // percent stall on the output side

	// a generous bound on the length of the whole run
	localparam int unsigned CYCLE_LIMIT = 2000000;

	always #5 clk = ~clk;

	stereo_spread_azimuth_pan_mixer dut (.*);

	stereo_spread_azimuth_pan_mixer_check chk (.*);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// receiver stalls at random
	always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_idle);

	// one transaction; valid stays high across back-to-back items
	task automatic send(logic [1:0] kind, logic [87:0] data);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 0;
			@(negedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= kind;
		s_tdata <= data;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_frame(logic [23:0] l, logic [23:0] r);
		send(REQ_FRAME, {40'd0, r, l});
	endtask

	task automatic send_word(logic [4:0] idx, logic [31:0] v);
		send(REQ_WORD, {3'd0, v, idx, 48'd0});
	endtask

	task automatic send_geo();
		send(REQ_GEO, 88'({$urandom, $urandom, $urandom}));
	endtask

	// quiet the input, drain results and let any geometry pass finish
	task automatic settle();
		s_tvalid <= 0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (400) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [16:0] v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	function automatic logic [23:0] rand_sample();
		case ($urandom_range(5))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return 24'(int'($urandom_range(200)) - 100);
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(5))
			0: return 32'(int'($urandom_range(131072)) - 65536);
			1: return 32'($urandom_range(200) - 100);
			2: return $urandom;
			default: return 32'(int'($urandom_range(1 << 22)) - (1 << 21));
		endcase
	endfunction

	task automatic random_settings();
		write_reg(CFG_BLEND, $urandom_range(3) == 0 ? 17'h1FFFF : 17'($urandom_range(65536)));
		write_reg(CFG_REVERB, $urandom_range(3) == 0 ? 17'h1FFFF : 17'($urandom_range(65536)));
		write_reg(CFG_PAN, 17'($urandom));
		write_reg(CFG_SPREAD, 17'($urandom_range(511)));
		write_reg(CFG_BYPASS, 17'($urandom_range(7) == 0));
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		send_idle = 17;
		recv_idle = 56;

		// directed: reset gains, extremes and the open cases
		send_frame(24'h7FFFFF, 24'h800000);
		send_frame(24'h000000, 24'hFFFFFF);
		settle();
		write_reg(CFG_BLEND, 17'd65536);
		write_reg(CFG_REVERB, 17'd65536);
		write_reg(CFG_PAN, 17'h08000);
		write_reg(CFG_SPREAD, 17'd360);
		send_word(5'd0, 32'h00010000);
		send_word(5'd10, 32'h00010000);
		send_word(5'd16, 32'h00030000);
		send_word(5'd18, 32'h00000020);   // z inside the dead zone
		send_word(5'd25, 32'hFFFFFFFF);   // ignored index
		send(REQ_RSVD, '1);               // ignored kind
		send_frame(24'h123456, 24'h800000);   // gains unchanged before update
		send_geo();
		send_frame(24'h7FFFFF, 24'h7FFFFF);
		send_word(5'd18, 32'h80000000);
		send_word(5'd16, 32'h7FFFFFFF);
		send_geo();
		send_frame(24'h800000, 24'h400000);
		settle();
		write_reg(CFG_BLEND, 17'h1FFFF);
		write_reg(CFG_REVERB, 17'h1FFFF);
		write_reg(CFG_PAN, 17'h07FFF);
		write_reg(CFG_SPREAD, 17'h1FF);
		send_geo();
		send_frame(24'h7FFFFF, 24'h800000);
		settle();
		write_reg(CFG_BYPASS, 17'd1);
		send_frame(24'h800000, 24'h7FFFFF);
		settle();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle = ph == 0 ? 17 : (ph == 1 ? 56 : 0);
			recv_idle = ph == 0 ? 56 : (ph == 1 ? 17 : 0);
			for (int blk = 0; blk < 5; blk++) begin
				random_settings();
				for (int n = 0; n < 100; n++) begin
					case ($urandom_range(19))
						0, 1, 2, 3: send_word(5'($urandom_range(18)), rand_word());
						4: send_word(5'($urandom_range(31)), rand_word());
						5: send_geo();
						6: send(REQ_RSVD, 88'({$urandom, $urandom, $urandom}));
						default: send_frame(rand_sample(), rand_sample());
					endcase
				end
				settle();
			end
		end

		s_tvalid <= 0;
		settle();
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
